[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the fill engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, off while reset is asserted
`define RFSO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication form: when ante holds, cons must hold in the same cycle
`define RFSO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[design/rfso_pkg.sv]
// ----------------------------------------------------------------------------
// rfso_pkg
// Shared types and constants of the premultiplied ARGB8888 rectangle fill engine.
// ----------------------------------------------------------------------------
package rfso_pkg;

  localparam int PIX_W     = 32;
  localparam int CH_W      = 8;
  localparam int CNT_W     = 13;
  localparam int CFG_W     = 7;
  localparam int COORD_W   = 16;
  localparam int RD_W      = 6;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam logic [CFG_W-1:0] CANVAS_RESET = 7'd64;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H = 1'b1;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_right;
    logic signed [COORD_W-1:0] rect_bottom;
    logic [CH_W-1:0]           alpha;
    logic [CH_W-1:0]           red;
    logic [CH_W-1:0]           green;
    logic [CH_W-1:0]           blue;
    logic [RD_W-1:0]           read_x;
    logic [RD_W-1:0]           read_y;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [CNT_W-1:0] pixels_touched;
  } out_item_t;

endpackage

[design/rect_fill_source_over_engine.sv]
// ----------------------------------------------------------------------------
// rect_fill_source_over_engine
// Clear / fill / read engine over a premultiplied ARGB8888 frame store.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : command item (clear, blended rectangle fill, pixel read); taken
//           when in_valid is high and in_stall low. One item in work at a time.
//   out_* : exactly one result item per command, held in an output register
//           while out_stall is high; a new command may be taken meanwhile.
//   cfg_* : canvas width / height, index 0 / 1, always ready; write only while
//           the engine is idle.
// Flow: clear and fill sweep one covered pixel per cycle over the frame store
//   read port (read, blend, write back in the next cycle). An item passes
//   through PREP, RUN and DONE; the result is registered as DONE is left,
//   and the next item can be taken once the engine is back in IDLE.
//   A read passes through READ and DONE; an empty command only through DONE.
// Reset: after rst_n releases, a clearing pass writes zero to all
//   MAX_WIDTH*MAX_HEIGHT entries, one per cycle, and in_stall stays high
//   until it finishes.
// A stalled result only delays the end of the next command; the pixel sweep
//   itself never waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rect_fill_source_over_engine #(
  parameter int MAX_WIDTH  = rfso_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rfso_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rfso_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rfso_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rfso_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfso_pkg::CFG_W-1:0]     cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = rfso_pkg::CFG_W;
  localparam int PW    = rfso_pkg::PIX_W;
  localparam int CH    = rfso_pkg::CH_W;
  localparam logic [AW-1:0] STRIDE   = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);

  typedef enum logic [5:0] {
    ST_INIT = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_PREP = 6'b000100,
    ST_RUN  = 6'b001000,
    ST_READ = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  // round-half-up of product/255 for product = channel*alpha
  function automatic logic [CH-1:0] premul(input logic [2*CH-1:0] prod);
    logic [16:0] m;
    logic [16:0] q0;
    logic [16:0] r;
    m  = {1'b0, prod} + 17'd127;
    q0 = (m + (m >> 8)) >> 8;
    r  = m - ((q0 << 8) - q0);
    premul = (r >= 17'd255) ? CH'(q0 + 17'd1) : CH'(q0);
  endfunction

  state_t state_r, state_nxt;

  logic [CW-1:0] cw_r, ch_r;
  logic [CW-1:0] used_w, used_h;

  logic [2*CH-1:0] prod_r_r, prod_g_r, prod_b_r;
  logic [CH-1:0]   alpha_r;
  logic [PW-1:0]   src_r;
  logic            clear_r;
  logic [CW-1:0]   lo_x_r, hi_x_r, hi_y_r;
  logic [CW-1:0]   x_r, y_r;
  logic [rfso_pkg::RD_W-1:0] rd_x_r, rd_y_r;
  logic            rd_sel_r;
  logic [rfso_pkg::CNT_W-1:0] cnt_r;

  logic            p1_valid_r;
  logic [AW-1:0]   p1_addr_r;
  logic [AW-1:0]   clr_addr_r;

  logic                out_valid_r;
  rfso_pkg::out_item_t out_data_r;

  logic          in_acc;
  logic          out_free;
  logic [CW-1:0] x_inc, y_inc;
  logic          row_end;

  logic signed [16:0] lft, top, rgt, bot, wlim, hlim;
  logic signed [16:0] lft_c, top_c, rgt_c, bot_c;
  logic               fill_empty, clear_empty, rd_hit;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [PW-1:0] mem_wdata, mem_rdata, blend_pix;

  assign used_w = (int'(cw_r) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : cw_r;
  assign used_h = (int'(ch_r) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : ch_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // clipping of the incoming rectangle
  always_comb begin
    lft  = {in_data.rect_left[15],   in_data.rect_left};
    top  = {in_data.rect_top[15],    in_data.rect_top};
    rgt  = {in_data.rect_right[15],  in_data.rect_right};
    bot  = {in_data.rect_bottom[15], in_data.rect_bottom};
    wlim = signed'({10'd0, used_w});
    hlim = signed'({10'd0, used_h});
    lft_c = (lft < 17'sd0) ? 17'sd0 : lft;
    top_c = (top < 17'sd0) ? 17'sd0 : top;
    rgt_c = (rgt > wlim) ? wlim : rgt;
    bot_c = (bot > hlim) ? hlim : bot;
    fill_empty  = (rgt_c <= lft_c) || (bot_c <= top_c);
    clear_empty = (used_w == '0) || (used_h == '0);
    rd_hit = ({1'b0, in_data.read_x} < used_w) && ({1'b0, in_data.read_y} < used_h);
  end

  assign x_inc   = CW'(x_r + CW'(1));
  assign y_inc   = CW'(y_r + CW'(1));
  assign row_end = (x_inc == hi_x_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= rfso_pkg::CANVAS_RESET;
      ch_r <= rfso_pkg::CANVAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rfso_pkg::REG_CANVAS_W: cw_r <= cfg_data;
        rfso_pkg::REG_CANVAS_H: ch_r <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (clr_addr_r == LAST_ADR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.command)
            rfso_pkg::CMD_CLEAR: state_nxt = clear_empty ? ST_DONE : ST_PREP;
            rfso_pkg::CMD_FILL:  state_nxt = (fill_empty || clear_empty) ? ST_DONE
                                                                          : ST_PREP;
            rfso_pkg::CMD_READ:  state_nxt = ST_READ;
            default:             state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PREP: state_nxt = ST_RUN;
      ST_RUN: begin
        if (row_end && (y_inc == hi_y_r)) state_nxt = ST_DONE;
      end
      ST_READ: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      clr_addr_r <= '0;
      p1_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      p1_valid_r <= (state_r == ST_RUN);
      if (state_r == ST_INIT) clr_addr_r <= AW'(clr_addr_r + AW'(1));
    end
  end

  // per-command context
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod_r_r <= in_data.red   * in_data.alpha;
      prod_g_r <= in_data.green * in_data.alpha;
      prod_b_r <= in_data.blue  * in_data.alpha;
      alpha_r  <= in_data.alpha;
      clear_r  <= (in_data.command == rfso_pkg::CMD_CLEAR);
      rd_x_r   <= in_data.read_x;
      rd_y_r   <= in_data.read_y;
      rd_sel_r <= (in_data.command == rfso_pkg::CMD_READ) && rd_hit;
      cnt_r    <= '0;
      if (in_data.command == rfso_pkg::CMD_CLEAR) begin
        lo_x_r <= '0;
        hi_x_r <= used_w;
        hi_y_r <= used_h;
        x_r    <= '0;
        y_r    <= '0;
      end else begin
        lo_x_r <= CW'(lft_c);
        hi_x_r <= CW'(rgt_c);
        hi_y_r <= CW'(bot_c);
        x_r    <= CW'(lft_c);
        y_r    <= CW'(top_c);
      end
    end else if (state_r == ST_RUN) begin
      cnt_r <= rfso_pkg::CNT_W'(cnt_r + rfso_pkg::CNT_W'(1));
      if (row_end) begin
        x_r <= lo_x_r;
        y_r <= y_inc;
      end else begin
        x_r <= x_inc;
      end
    end
    if (state_r == ST_PREP) begin
      src_r <= {alpha_r, premul(prod_r_r), premul(prod_g_r), premul(prod_b_r)};
    end
    p1_addr_r <= mem_raddr;
  end

  // frame store ports: clearing pass, then read in RUN / READ, write back of sweep reads next cycle
  always_comb begin
    mem_re    = (state_r == ST_RUN) || (state_r == ST_READ);
    mem_raddr = (state_r == ST_READ)
              ? AW'(AW'(rd_y_r) * STRIDE + AW'(rd_x_r))
              : AW'(AW'(y_r) * STRIDE + AW'(x_r));
    mem_we    = (state_r == ST_INIT) || p1_valid_r;
    mem_waddr = (state_r == ST_INIT) ? clr_addr_r : p1_addr_r;
    mem_wdata = (state_r == ST_INIT) ? '0 : blend_pix;
  end

  rfso_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rfso_blend u_blend (
    .src_pix (src_r),
    .dst_pix (mem_rdata),
    .copy    (clear_r),
    .result  (blend_pix)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r.pixel_value    <= rd_sel_r ? mem_rdata : '0;
      out_data_r.pixels_touched <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // read and write back never hit the same entry in one cycle
  `RFSO_ASSERT_IMP(a_no_rmw_overlap, mem_re && mem_we && (state_r != ST_INIT),
                   mem_raddr != mem_waddr, "frame store read and write collide")
  // write-back follows a sweep read only
  `RFSO_ASSERT_IMP(a_wb_after_run, p1_valid_r, $past(state_r == ST_RUN),
                   "write-back without a preceding sweep read")
  // sweep stays inside the clipped rectangle
  `RFSO_ASSERT_IMP(a_sweep_bounds, state_r == ST_RUN,
                   (x_r >= lo_x_r) && (x_r < hi_x_r) && (y_r < hi_y_r),
                   "sweep left the clipped rectangle")
  // a result appears only at the end of a command
  `RFSO_ASSERT_IMP(a_result_source, $rose(out_valid_r), $past(state_r == ST_DONE),
                   "result issued outside of command completion")
  // no command taken during the clearing pass
  `RFSO_ASSERT_IMP(a_init_blocks, state_r == ST_INIT, in_stall,
                   "input taken during clearing pass")

endmodule

[design/rfso_mem.sv]
// ----------------------------------------------------------------------------
// rfso_mem
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rfso_mem #(
  parameter int DEPTH = rfso_pkg::MAX_WIDTH_DEF * rfso_pkg::MAX_HEIGHT_DEF,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [rfso_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [rfso_pkg::PIX_W-1:0] rdata
);

  logic [rfso_pkg::PIX_W-1:0] mem [DEPTH];
  logic [rfso_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/rfso_blend.sv]
// ----------------------------------------------------------------------------
// rfso_blend
// Source-over blend of a premultiplied source onto one stored pixel.
// ----------------------------------------------------------------------------
module rfso_blend (
  input  logic [rfso_pkg::PIX_W-1:0] src_pix,
  input  logic [rfso_pkg::PIX_W-1:0] dst_pix,
  input  logic                       copy,      // clear: write source as is
  output logic [rfso_pkg::PIX_W-1:0] result
);

  localparam int CH_W = rfso_pkg::CH_W;
  localparam int NCH  = rfso_pkg::PIX_W / CH_W;

  logic [CH_W-1:0] inv_a;
  logic [NCH*CH_W-1:0] mix;

  assign inv_a = ~src_pix[rfso_pkg::PIX_W-1 -: CH_W];   // 255 - srcA

  always_comb begin
    logic [2*CH_W-1:0] prod;
    logic [2*CH_W:0]   t;
    logic [2*CH_W+8:0] p;
    logic [CH_W:0]     v;
    mix = '0;
    for (int c = 0; c < NCH; c++) begin
      prod = inv_a * dst_pix[c*CH_W +: CH_W];
      // div255(n) = ((n + 128) * 257) >> 16
      t = {1'b0, prod} + 17'd128;
      p = {8'd0, t} + {t, 8'd0};
      v = {1'b0, src_pix[c*CH_W +: CH_W]} + {1'b0, p[23:16]};
      mix[c*CH_W +: CH_W] = v[CH_W] ? {CH_W{1'b1}} : v[CH_W-1:0];
    end
  end

  assign result = copy ? src_pix : mix;

endmodule
